// File: hdl/tcph_pkg.sv
package tcph_pkg;

   localparam int TCPH_BINS        = 256;
   localparam int TCPH_COUNT_WIDTH = 24;
   localparam int TCPH_CHANNELS    = 3;

   localparam int VALUE_WIDTH        = 8;
   localparam int CHANNEL_CODE_WIDTH = 2;
   localparam int OUT_COUNT_WIDTH    = 24;

   localparam logic OP_ACCUMULATE = 1'b0;
   localparam logic OP_READ       = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FINISH
   } tcph_state_type;

   typedef struct packed {
      logic accept;
      logic clear_en;
      logic commit;
      logic load_rsp;
   } tcph_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic item_is_read;
      logic rsp_free;
   } tcph_status_type;

endpackage

// File: hdl/tcph_req_if.sv
interface tcph_req_if
   import tcph_pkg::*;
   ;
   logic                          valid;
   logic                          ready;
   logic                          operation;
   logic [VALUE_WIDTH-1:0]        blue_value;
   logic [VALUE_WIDTH-1:0]        green_value;
   logic [VALUE_WIDTH-1:0]        red_value;
   logic [CHANNEL_CODE_WIDTH-1:0] read_channel;
   logic [VALUE_WIDTH-1:0]        read_bin;

   modport source (
      output valid, operation, blue_value, green_value, red_value, read_channel, read_bin,
      input  ready
   );

   modport sink (
      input  valid, operation, blue_value, green_value, red_value, read_channel, read_bin,
      output ready
   );
endinterface

// File: hdl/tcph_rsp_if.sv
interface tcph_rsp_if
   import tcph_pkg::*;
   ;
   logic                       valid;
   logic                       ready;
   logic [OUT_COUNT_WIDTH-1:0] bin_count;

   modport source (
      output valid, bin_count,
      input  ready
   );

   modport sink (
      input  valid, bin_count,
      output ready
   );
endinterface

// File: hdl/tcph_controller.sv
module tcph_controller
   import tcph_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  tcph_status_type status,
   output tcph_cmd_type    cmd
);

   tcph_state_type state_ff;
   tcph_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.item_is_read) begin
               if (status.rsp_free) begin
                  cmd.load_rsp = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

// File: hdl/tcph_datapath.sv
module tcph_datapath
   import tcph_pkg::*;
#(
   parameter int BINS        = TCPH_BINS,
   parameter int COUNT_WIDTH = TCPH_COUNT_WIDTH,
   parameter int CHANNELS    = TCPH_CHANNELS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic                          csr_write_data,
   input  logic                          req_operation,
   input  logic [VALUE_WIDTH-1:0]        req_blue_value,
   input  logic [VALUE_WIDTH-1:0]        req_green_value,
   input  logic [VALUE_WIDTH-1:0]        req_red_value,
   input  logic [CHANNEL_CODE_WIDTH-1:0] req_read_channel,
   input  logic [VALUE_WIDTH-1:0]        req_read_bin,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [OUT_COUNT_WIDTH-1:0]    rsp_bin_count,
   input  tcph_cmd_type                  cmd,
   output tcph_status_type               status
);

   localparam int BIN_W = $clog2(BINS);

   logic                          mode_ff;
   logic                          op_ff;
   logic [VALUE_WIDTH-1:0]        value_ff [CHANNELS];
   logic [CHANNEL_CODE_WIDTH-1:0] read_chan_ff;
   logic [VALUE_WIDTH-1:0]        read_bin_ff;
   logic [BIN_W-1:0]              clear_addr_ff;
   logic [COUNT_WIDTH-1:0]        rd_data_ff [CHANNELS];
   logic                          rsp_valid_ff;
   logic [OUT_COUNT_WIDTH-1:0]    rsp_count_ff;

   logic [VALUE_WIDTH-1:0]        pix_value [CHANNELS];
   logic [COUNT_WIDTH-1:0]        sel_count;
   logic                          read_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b1;
      end else if (csr_write_enable) begin
         mode_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
      end else if (cmd.clear_en) begin
         clear_addr_ff <= clear_addr_ff + BIN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff        <= req_operation;
         read_chan_ff <= req_read_channel;
         read_bin_ff  <= req_read_bin;
      end
   end

   for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
      logic [COUNT_WIDTH-1:0] bin_mem [BINS];
      logic [BIN_W-1:0]       rd_addr;
      logic [BIN_W-1:0]       wr_addr;
      logic [COUNT_WIDTH-1:0] wr_data;
      logic                   wr_en;
      logic                   count_en;

      if (c == 0) begin : g_blue
         assign pix_value[c] = req_blue_value;
      end else if (c == 1) begin : g_green
         assign pix_value[c] = req_green_value;
      end else begin : g_red
         assign pix_value[c] = req_red_value;
      end

      always_comb begin
         if (req_operation == OP_READ) begin
            rd_addr = req_read_bin[BIN_W-1:0];
         end else begin
            rd_addr = pix_value[c][BIN_W-1:0];
         end
         count_en = ((c == 0) || mode_ff) && ({1'b0, value_ff[c]} < (VALUE_WIDTH + 1)'(BINS));
         wr_en    = cmd.clear_en || (cmd.commit && count_en);
         if (cmd.clear_en) begin
            wr_addr = clear_addr_ff;
            wr_data = '0;
         end else begin
            wr_addr = value_ff[c][BIN_W-1:0];
            if (rd_data_ff[c] == {COUNT_WIDTH{1'b1}}) begin
               wr_data = rd_data_ff[c];
            end else begin
               wr_data = rd_data_ff[c] + COUNT_WIDTH'(1);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (cmd.accept) begin
            value_ff[c]   <= pix_value[c];
            rd_data_ff[c] <= bin_mem[rd_addr];
         end
         if (wr_en) begin
            bin_mem[wr_addr] <= wr_data;
         end
      end
   end

   always_comb begin
      sel_count = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         if (read_chan_ff == CHANNEL_CODE_WIDTH'(c)) begin
            sel_count = rd_data_ff[c];
         end
      end
      read_ok = ({1'b0, read_bin_ff} < (VALUE_WIDTH + 1)'(BINS));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_count_ff <= read_ok ? OUT_COUNT_WIDTH'(sel_count) : '0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_bin_count       = rsp_count_ff;
   assign status.clear_last   = (clear_addr_ff == BIN_W'(BINS - 1));
   assign status.item_is_read = (op_ff == OP_READ);
   assign status.rsp_free     = !rsp_valid_ff || rsp_ready;

endmodule

// File: hdl/three_channel_pixel_histogram_core.sv
// Histogram engine with one bin counter per channel and bin value.
// Requests arrive on the req_chan channel: an accumulate transaction carries one
// pixel and bumps its blue bin and, in three-channel mode, its green and red bins;
// a read transaction names a channel and a bin. Counters saturate at full scale.
// Each read transaction gives exactly one transaction on rsp_chan; accumulates
// give none. The csr port writes the three-channel mode bit; the user must do so
// only while idle, and the block itself does not enforce it. The bin store is
// read through its registered port when a request is accepted in the idle state;
// in the finish state the count is written back or, for a read, loaded into the
// response register once that is free. A new request is accepted only when the
// last has left the finish state; a read leaves it as its count becomes valid on
// rsp_chan. After reset the bin store is cleared one bin of every channel per
// cycle, over all BINS bins (256 by default); no request is accepted during that
// pass. The response is registered. While a count waits to be taken, accumulates
// are still accepted; a further read is accepted, then stalls until that is taken.
module three_channel_pixel_histogram_core
   import tcph_pkg::*;
#(
   parameter int BINS        = TCPH_BINS,
   parameter int COUNT_WIDTH = TCPH_COUNT_WIDTH,
   parameter int CHANNELS    = TCPH_CHANNELS
) (
   input  logic       clock,
   input  logic       reset,
   tcph_req_if.sink   req_chan,
   tcph_rsp_if.source rsp_chan,
   input  logic       csr_write_enable,
   input  logic       csr_write_data
);

   tcph_cmd_type    cmd;
   tcph_status_type status;
   logic            req_ready;
   logic            rsp_valid;
   logic [OUT_COUNT_WIDTH-1:0] rsp_bin_count;

   tcph_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tcph_datapath #(
      .BINS        (BINS),
      .COUNT_WIDTH (COUNT_WIDTH),
      .CHANNELS    (CHANNELS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_operation    (req_chan.operation),
      .req_blue_value   (req_chan.blue_value),
      .req_green_value  (req_chan.green_value),
      .req_red_value    (req_chan.red_value),
      .req_read_channel (req_chan.read_channel),
      .req_read_bin     (req_chan.read_bin),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_bin_count    (rsp_bin_count),
      .cmd              (cmd),
      .status           (status)
   );

   assign req_chan.ready     = req_ready;
   assign rsp_chan.valid     = rsp_valid;
   assign rsp_chan.bin_count = rsp_bin_count;

`ifndef SYNTH
   a_cmd_exclusive : assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept, cmd.clear_en, cmd.commit, cmd.load_rsp}))
      else $error("more than one datapath command at once");

   a_one_item : assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> !req_ready)
      else $error("request accepted while another is in progress");

   a_rsp_slot : assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> status.rsp_free)
      else $error("response register overwritten before it was taken");

   a_reset_quiet : assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("block active straight after reset");
`endif

endmodule
